// ===== rtl/rm2q_pkg.sv =====
`default_nettype none

package rm2q_pkg;

	// Default word format: signed Q2.30
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 30;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Branch codes reported with each result
	localparam logic [1:0] BR_TRACE = 2'd0;
	localparam logic [1:0] BR_M11   = 2'd1;
	localparam logic [1:0] BR_M22   = 2'd2;
	localparam logic [1:0] BR_M00   = 2'd3;

	// Handshake status between the front register and the queue
	typedef struct packed {
		logic valid;
		logic full;
	} link_t;

endpackage

`default_nettype wire

// ===== rtl/rotation_matrix_to_quaternion.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// source    in         src_valid/src_stall  m00 .. m22
// result    out        res_valid/res_stall  quat_w quat_x quat_y quat_z branch_taken
//
// One matrix per cycle sustained while no result is stalled; a result passes
// through the front register, the queue, the root entry stage, the bit-per-stage
// root and divider pipelines and the output register (words Q2.30 by default).
// arst_n clears all valid flags and the queue; data registers are not reset.
// A stalled result freezes the back pipeline; the front keeps taking
// transfers until its register and the queue are full.
module rotation_matrix_to_quaternion #(
	parameter int WORD_BITS = rm2q_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         src_valid,
	output logic                        src_stall,
	input  wire  signed [WORD_BITS-1:0] m00,
	input  wire  signed [WORD_BITS-1:0] m01,
	input  wire  signed [WORD_BITS-1:0] m02,
	input  wire  signed [WORD_BITS-1:0] m10,
	input  wire  signed [WORD_BITS-1:0] m11,
	input  wire  signed [WORD_BITS-1:0] m12,
	input  wire  signed [WORD_BITS-1:0] m20,
	input  wire  signed [WORD_BITS-1:0] m21,
	input  wire  signed [WORD_BITS-1:0] m22,
	output logic                        res_valid,
	input  wire                         res_stall,
	output logic signed [WORD_BITS-1:0] quat_w,
	output logic signed [WORD_BITS-1:0] quat_x,
	output logic signed [WORD_BITS-1:0] quat_y,
	output logic signed [WORD_BITS-1:0] quat_z,
	output logic [1:0]                  branch_taken
);

	localparam int W  = WORD_BITS;
	localparam int DB = (W + 2) + 3 * (W + 1) + 2;

	rm2q_pkg::link_t front_link, queue_link;
	logic [W+1:0]    f_arg, q_arg;
	logic [W:0]      f_s0, f_s1, f_s2, q_s0, q_s1, q_s2;
	logic [1:0]      f_br, q_br;
	logic            q_not_empty, pop;

	rm2q_front #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.m00      (m00),
		.m01      (m01),
		.m02      (m02),
		.m10      (m10),
		.m11      (m11),
		.m12      (m12),
		.m20      (m20),
		.m21      (m21),
		.m22      (m22),
		.link_in  (queue_link),
		.link_out (front_link),
		.arg      (f_arg),
		.s0       (f_s0),
		.s1       (f_s1),
		.s2       (f_s2),
		.br       (f_br)
	);

	rm2q_queue #(
		.DATA_BITS(DB)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.link_in  (front_link),
		.link_out (queue_link),
		.pop      (pop),
		.wr_data  ({f_arg, f_s0, f_s1, f_s2, f_br}),
		.rd_data  ({q_arg, q_s0, q_s1, q_s2, q_br}),
		.not_empty(q_not_empty)
	);

	rm2q_back #(
		.WORD_BITS(WORD_BITS),
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (q_not_empty),
		.pop         (pop),
		.arg         (q_arg),
		.s0          (q_s0),
		.s1          (q_s1),
		.s2          (q_s2),
		.br          (q_br),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.quat_w      (quat_w),
		.quat_x      (quat_x),
		.quat_y      (quat_y),
		.quat_z      (quat_z),
		.branch_taken(branch_taken)
	);

	// The component taken from the root is never negative
	a_trace_w_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && branch_taken == rm2q_pkg::BR_TRACE |-> !quat_w[W-1])
		else $error("root component w negative");

	a_m00_x_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && branch_taken == rm2q_pkg::BR_M00 |-> !quat_x[W-1])
		else $error("root component x negative");

	a_m11_y_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && branch_taken == rm2q_pkg::BR_M11 |-> !quat_y[W-1])
		else $error("root component y negative");

	// The front only holds off its source when the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> queue_link.full && front_link.valid)
		else $error("source stalled without a full queue");

endmodule

`default_nettype wire

// ===== rtl/rm2q_front.sv =====
`default_nettype none

// Front: takes a matrix, picks the branch, forms the root argument and the
// three off-diagonal sums or differences, and holds them for the queue.
module rm2q_front #(
	parameter int WORD_BITS = rm2q_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         src_valid,
	output logic                        src_stall,
	input  wire  signed [WORD_BITS-1:0] m00,
	input  wire  signed [WORD_BITS-1:0] m01,
	input  wire  signed [WORD_BITS-1:0] m02,
	input  wire  signed [WORD_BITS-1:0] m10,
	input  wire  signed [WORD_BITS-1:0] m11,
	input  wire  signed [WORD_BITS-1:0] m12,
	input  wire  signed [WORD_BITS-1:0] m20,
	input  wire  signed [WORD_BITS-1:0] m21,
	input  wire  signed [WORD_BITS-1:0] m22,
	input  wire  rm2q_pkg::link_t       link_in,
	output rm2q_pkg::link_t             link_out,
	output logic [WORD_BITS+1:0]        arg,
	output logic [WORD_BITS:0]          s0,
	output logic [WORD_BITS:0]          s1,
	output logic [WORD_BITS:0]          s2,
	output logic [1:0]                  br
);

	localparam int W  = WORD_BITS;
	localparam int AW = WORD_BITS + 3;
	localparam int SW = WORD_BITS + 1;
	localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

	logic signed [AW-1:0] tr_c;
	logic signed [AW-1:0] arg_c;
	logic signed [SW-1:0] s0_c, s1_c, s2_c;
	logic [1:0]           br_c;
	logic                 valid_s1;
	logic                 accept;
	logic                 push;

	// Classify and form the operands
	always_comb begin
		tr_c = AW'(m00) + AW'(m11) + AW'(m22);
		if (tr_c > 0) begin
			br_c  = rm2q_pkg::BR_TRACE;
			arg_c = tr_c + ONE;
			s0_c  = SW'(m21) - SW'(m12);
			s1_c  = SW'(m02) - SW'(m20);
			s2_c  = SW'(m10) - SW'(m01);
		end else if (m11 > m00 && m11 > m22) begin
			br_c  = rm2q_pkg::BR_M11;
			arg_c = AW'(m11) - AW'(m00) - AW'(m22) + ONE;
			s0_c  = SW'(m02) - SW'(m20);
			s1_c  = SW'(m10) + SW'(m01);
			s2_c  = SW'(m21) + SW'(m12);
		end else if (m22 > m00) begin
			br_c  = rm2q_pkg::BR_M22;
			arg_c = AW'(m22) - AW'(m00) - AW'(m11) + ONE;
			s0_c  = SW'(m10) - SW'(m01);
			s1_c  = SW'(m02) + SW'(m20);
			s2_c  = SW'(m21) + SW'(m12);
		end else begin
			br_c  = rm2q_pkg::BR_M00;
			arg_c = AW'(m00) - AW'(m11) - AW'(m22) + ONE;
			s0_c  = SW'(m21) - SW'(m12);
			s1_c  = SW'(m10) + SW'(m01);
			s2_c  = SW'(m02) + SW'(m20);
		end
	end

	assign src_stall = valid_s1 && link_in.full;
	assign accept    = src_valid && !src_stall;
	assign push      = valid_s1 && !link_in.full;

	// Holding register; a negative argument clamps to zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			arg <= arg_c[AW-1] ? '0 : arg_c[W+1:0];
			s0  <= s0_c;
			s1  <= s1_c;
			s2  <= s2_c;
			br  <= br_c;
		end
	end

	assign link_out.valid = valid_s1;
	assign link_out.full  = 1'b0;

endmodule

`default_nettype wire

// ===== rtl/rm2q_queue.sv =====
`default_nettype none

// Short queue between front and back
module rm2q_queue #(
	parameter int DATA_BITS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire  rm2q_pkg::link_t link_in,
	output rm2q_pkg::link_t       link_out,
	input  wire                   pop,
	input  wire  [DATA_BITS-1:0]  wr_data,
	output logic [DATA_BITS-1:0]  rd_data,
	output logic                  not_empty
);

	localparam int DEPTH = rm2q_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [DATA_BITS-1:0] mem [DEPTH];
	logic [PW-1:0]        wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]        count_q;
	logic                 push, do_pop, full;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign push      = link_in.valid && !full;
	assign do_pop    = pop && not_empty;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	assign rd_data        = mem[rd_ptr_q];
	assign link_out.valid = not_empty;
	assign link_out.full  = full;

endmodule

`default_nettype wire

// ===== rtl/rm2q_back.sv =====
`default_nettype none

// Back: pipelined square root (one root bit per stage), then three
// pipelined divisions by twice the root (one quotient bit per stage),
// then saturation and placement of the components.
module rm2q_back #(
	parameter int WORD_BITS = rm2q_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         head_valid,
	output logic                        pop,
	input  wire  [WORD_BITS+1:0]        arg,
	input  wire  [WORD_BITS:0]          s0,
	input  wire  [WORD_BITS:0]          s1,
	input  wire  [WORD_BITS:0]          s2,
	input  wire  [1:0]                  br,
	output logic                        res_valid,
	input  wire                         res_stall,
	output logic signed [WORD_BITS-1:0] quat_w,
	output logic signed [WORD_BITS-1:0] quat_x,
	output logic signed [WORD_BITS-1:0] quat_y,
	output logic signed [WORD_BITS-1:0] quat_z,
	output logic [1:0]                  branch_taken
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int RB  = (WORD_BITS + FRAC_BITS + 3) / 2;
	localparam int SQW = 2 * RB;
	localparam int MXW = (FRAC_BITS > RB) ? FRAC_BITS : RB;
	localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

	typedef struct packed {
		logic [SQW-1:0]     val;
		logic [RB+1:0]      rem;
		logic [RB-1:0]      root;
		logic [2:0][W:0]    s;
		logic [1:0]         br;
	} sq_t;

	typedef struct packed {
		logic [RB-1:0]        r;
		logic [2:0]           neg;
		logic [2:0]           ovf;
		logic [2:0][RB-1:0]   rem;
		logic [2:0][W-1:0]    q;
		logic [2:0][W-1:0]    lo;
		logic [1:0]           br;
	} dv_t;

	sq_t  sq_s [RB+1];
	logic sq_v [RB+1];
	dv_t  dv_s [W+1];
	logic dv_v [W+1];
	logic adv;

	logic signed [W-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic [1:0]          branch_q;
	logic                res_valid_q;

	// Whole back pipeline moves together whenever the output can drain
	assign adv = !res_valid_q || !res_stall;
	assign pop = adv && head_valid;

	// Root entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (adv) begin
			sq_v[0] <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s[0].val  <= SQW'(arg) << F;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].s    <= {s2, s1, s0};
			sq_s[0].br   <= br;
		end
	end

	// Square root, one result bit per stage
	for (genvar k = 0; k < RB; k++) begin : g_sqrt
		logic [RB+3:0] rn, trial;
		logic          ge;
		sq_t           nxt;

		always_comb begin
			rn       = {sq_s[k].rem, sq_s[k].val[SQW-1 -: 2]};
			trial    = {2'b00, sq_s[k].root, 2'b01};
			ge       = (rn >= trial);
			nxt      = sq_s[k];
			nxt.rem  = ge ? (RB+2)'(rn - trial) : (RB+2)'(rn);
			nxt.root = {sq_s[k].root[RB-2:0], ge};
			nxt.val  = sq_s[k].val << 2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_s[k+1] <= nxt;
			end
		end
	end

	// Division set-up: magnitudes, scaling and the overflow test
	dv_t dv_init;

	always_comb begin
		logic [W:0]     mag;
		logic [W+F-1:0] num;
		logic [F-1:0]   nhi;
		dv_init    = '0;
		dv_init.r  = sq_s[RB].root;
		dv_init.br = sq_s[RB].br;
		for (int j = 0; j < 3; j++) begin
			dv_init.neg[j] = sq_s[RB].s[j][W];
			mag            = dv_init.neg[j] ? (W+1)'(-sq_s[RB].s[j]) : sq_s[RB].s[j];
			num            = (W+F)'(mag) << (F - 1);
			nhi            = num[W+F-1:W];
			dv_init.ovf[j] = (MXW'(nhi) >= MXW'(sq_s[RB].root));
			dv_init.rem[j] = dv_init.ovf[j] ? '0 : RB'(nhi);
			dv_init.lo[j]  = num[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (adv) begin
			dv_v[0] <= sq_v[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s[0] <= dv_init;
		end
	end

	// Restoring division, one quotient bit per stage for all three components
	for (genvar k = 0; k < W; k++) begin : g_div
		dv_t nxt;

		always_comb begin
			logic [RB:0] rem2;
			logic        ge;
			nxt = dv_s[k];
			for (int j = 0; j < 3; j++) begin
				rem2       = {dv_s[k].rem[j], dv_s[k].lo[j][W-1]};
				ge         = (rem2 >= {1'b0, dv_s[k].r});
				nxt.rem[j] = ge ? RB'(rem2 - {1'b0, dv_s[k].r}) : RB'(rem2);
				nxt.q[j]   = {dv_s[k].q[j][W-2:0], ge};
				nxt.lo[j]  = dv_s[k].lo[j] << 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[k+1] <= 1'b0;
			end else if (adv) begin
				dv_v[k+1] <= dv_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[k+1] <= nxt;
			end
		end
	end

	// Saturation and placement
	logic [2:0][W-1:0] comp;
	logic [W-1:0]      half;
	logic [W-1:0]      w_c, x_c, y_c, z_c;

	always_comb begin
		if ((RB+W)'(dv_s[W].r >> 1) > (RB+W)'(MAXPOS)) begin
			half = MAXPOS;
		end else begin
			half = W'(dv_s[W].r >> 1);
		end
		for (int j = 0; j < 3; j++) begin
			if (dv_s[W].r == '0) begin
				comp[j] = '0;
			end else if (dv_s[W].neg[j]) begin
				comp[j] = (dv_s[W].ovf[j] || dv_s[W].q[j][W-1]) ? MINNEG : -dv_s[W].q[j];
			end else begin
				comp[j] = (dv_s[W].ovf[j] || dv_s[W].q[j][W-1]) ? MAXPOS : dv_s[W].q[j];
			end
		end
		unique case (dv_s[W].br)
			rm2q_pkg::BR_TRACE: begin
				w_c = half;    x_c = comp[0]; y_c = comp[1]; z_c = comp[2];
			end
			rm2q_pkg::BR_M11: begin
				w_c = comp[0]; x_c = comp[1]; y_c = half;    z_c = comp[2];
			end
			rm2q_pkg::BR_M22: begin
				w_c = comp[0]; x_c = comp[1]; y_c = comp[2]; z_c = half;
			end
			rm2q_pkg::BR_M00: begin
				w_c = comp[0]; x_c = half;    y_c = comp[1]; z_c = comp[2];
			end
			// bubbles carry unwritten data
			default: begin
				w_c = '0;      x_c = '0;      y_c = '0;      z_c = '0;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= dv_v[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && dv_v[W]) begin
			quat_w_q <= w_c;
			quat_x_q <= x_c;
			quat_y_q <= y_c;
			quat_z_q <= z_c;
			branch_q <= dv_s[W].br;
		end
	end

	assign res_valid    = res_valid_q;
	assign quat_w       = quat_w_q;
	assign quat_x       = quat_x_q;
	assign quat_y       = quat_y_q;
	assign quat_z       = quat_z_q;
	assign branch_taken = branch_q;

endmodule

`default_nettype wire
